FILE: rtl/dsr_pkg.sv
// ----------------------------------------------------------------------------
// dsr_pkg
// Shared types and constants for the DMX slot receiver with PWM outputs.
// ----------------------------------------------------------------------------
package dsr_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned PINS_W  = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK   = 1'b1;

  // Reset values of the configuration registers and the tick counter
  localparam logic [SLOT_W-1:0] START_ADDRESS_RST = 10'd1;
  localparam logic [BYTE_W-1:0] INVERT_MASK_RST   = 8'hff;
  localparam logic [BYTE_W-1:0] TICK_COUNT_RST    = 8'hff;

  // Item request type
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Receiver phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_BREAK   = 4'b0010,
    PH_COUNT   = 4'b0100,
    PH_CAPTURE = 4'b1000
  } phase_t;

  // Phase codes as reported on the result channel
  localparam logic [PHASE_W-1:0] CODE_IDLE    = 2'd0;
  localparam logic [PHASE_W-1:0] CODE_BREAK   = 2'd1;
  localparam logic [PHASE_W-1:0] CODE_COUNT   = 2'd2;
  localparam logic [PHASE_W-1:0] CODE_CAPTURE = 2'd3;

  // Input item held in the input register
  typedef struct packed {
    logic              req_type;
    logic [BYTE_W-1:0] rx_byte;
    logic              framing_error;
  } item_t;

  // Per-cycle work strobe handed to the receiver and PWM units
  typedef struct packed {
    logic              byte_en;
    logic              tick_en;
    logic [BYTE_W-1:0] data;
    logic              brk;
  } step_t;

  function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
    logic [PHASE_W-1:0] code;
    unique case (ph)
      PH_IDLE:    code = CODE_IDLE;
      PH_BREAK:   code = CODE_BREAK;
      PH_COUNT:   code = CODE_COUNT;
      PH_CAPTURE: code = CODE_CAPTURE;
      default:    code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/dmx_slot_receiver_8ch_pwm.sv
// ----------------------------------------------------------------------------
// dmx_slot_receiver_8ch_pwm
// DMX512 slot receiver driving software PWM outputs.
// Path: an item passes through the input register, then the result register;
//   a stalled result channel holds it in the input register.
// Throughput: one item per cycle while the result channel is not stalled, set by the single-pass update stage.
// Reset: synchronous, active low; clears phase, slot counter, levels and PWM
//   bits, loads the tick counter with 255 and the registers with their defaults.
// ----------------------------------------------------------------------------
module dmx_slot_receiver_8ch_pwm #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_req_type,
  input  logic [dsr_pkg::BYTE_W-1:0]         in_rx_byte,
  input  logic                               in_framing_error,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dsr_pkg::PINS_W-1:0]         out_pwm_pins,
  output logic [dsr_pkg::PHASE_W-1:0]        out_rx_phase,
  // configuration
  input  logic                               cfg_we,
  input  logic [dsr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dsr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [dsr_pkg::SLOT_W-1:0]               start_address_r;
  logic [dsr_pkg::BYTE_W-1:0]               invert_mask_r;
  logic                                     s1_valid_r;
  dsr_pkg::item_t                           s1_item_r;
  logic                                     s1_adv;
  dsr_pkg::step_t                           step;
  logic [CHANNELS-1:0][dsr_pkg::BYTE_W-1:0] levels;
  logic [dsr_pkg::PHASE_W-1:0]              phase_code_nxt;
  logic [dsr_pkg::PINS_W-1:0]               shown;
  logic                                     out_valid_r;
  logic [dsr_pkg::PINS_W-1:0]               out_pwm_pins_r;
  logic [dsr_pkg::PHASE_W-1:0]              out_rx_phase_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_address_r <= dsr_pkg::START_ADDRESS_RST;
      invert_mask_r   <= dsr_pkg::INVERT_MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dsr_pkg::REG_START_ADDRESS: start_address_r <= cfg_wdata[dsr_pkg::SLOT_W-1:0];
        dsr_pkg::REG_INVERT_MASK:   invert_mask_r   <= cfg_wdata[dsr_pkg::BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Move the held item into the result register when that register is free
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= '{req_type: in_req_type, rx_byte: in_rx_byte,
                     framing_error: in_framing_error};
    end
  end

  // Decode the held item into a work strobe
  always_comb begin
    step.byte_en = s1_adv && (s1_item_r.req_type == dsr_pkg::REQ_BYTE);
    step.tick_en = s1_adv && (s1_item_r.req_type == dsr_pkg::REQ_TICK);
    step.data    = s1_item_r.rx_byte;
    step.brk     = s1_item_r.framing_error;
  end

  dsr_rx #(
    .CHANNELS(CHANNELS)
  ) u_rx (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_i        (step),
    .start_address (start_address_r),
    .phase_code_nxt(phase_code_nxt),
    .levels        (levels)
  );

  dsr_pwm #(
    .CHANNELS(CHANNELS)
  ) u_pwm (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_i     (step),
    .levels     (levels),
    .invert_mask(invert_mask_r),
    .shown      (shown)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pwm_pins_r <= shown;
      out_rx_phase_r <= phase_code_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pwm_pins = out_pwm_pins_r;
  assign out_rx_phase = out_rx_phase_r;

  // A held item that cannot move stays put
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_item_r))
    else $error("input register lost an item while stalled");

  // Every move out of the input register produces a result
  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("transfer did not produce a result");

endmodule

FILE: rtl/dsr_rx.sv
// ----------------------------------------------------------------------------
// dsr_rx
// DMX receiver: tracks break, start code and slot number, and stores the
// levels of the configured channel window.
// ----------------------------------------------------------------------------
module dsr_rx #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  dsr_pkg::step_t                           step_i,
  input  logic [dsr_pkg::SLOT_W-1:0]               start_address,
  output logic [dsr_pkg::PHASE_W-1:0]              phase_code_nxt,
  output logic [CHANNELS-1:0][dsr_pkg::BYTE_W-1:0] levels
);

  dsr_pkg::phase_t                           phase_r, phase_nxt;
  logic [dsr_pkg::SLOT_W-1:0]                slot_r, slot_nxt;
  logic [CHANNELS-1:0][dsr_pkg::BYTE_W-1:0]  levels_r, levels_nxt;
  logic [dsr_pkg::SLOT_W-1:0]                slot_dec;
  logic [dsr_pkg::SLOT_W-1:0]                slot_inc;

  assign slot_dec = slot_r - 10'd1;
  assign slot_inc = slot_r + 10'd1;

  // Advance the receiver on each byte transfer
  always_comb begin
    phase_nxt  = phase_r;
    slot_nxt   = slot_r;
    levels_nxt = levels_r;
    if (step_i.byte_en) begin
      if (step_i.brk) begin
        slot_nxt  = start_address;
        phase_nxt = dsr_pkg::PH_BREAK;
      end else begin
        unique case (phase_r)
          dsr_pkg::PH_BREAK: begin
            phase_nxt = (step_i.data == '0) ? dsr_pkg::PH_COUNT : dsr_pkg::PH_IDLE;
          end
          dsr_pkg::PH_COUNT: begin
            if (slot_dec == '0) begin
              slot_nxt      = 10'd1;
              levels_nxt[0] = step_i.data;
              phase_nxt     = (CHANNELS <= 1) ? dsr_pkg::PH_IDLE : dsr_pkg::PH_CAPTURE;
            end else begin
              slot_nxt = slot_dec;
            end
          end
          dsr_pkg::PH_CAPTURE: begin
            for (int unsigned i = 0; i < CHANNELS; i++) begin
              if (slot_r == dsr_pkg::SLOT_W'(i)) levels_nxt[i] = step_i.data;
            end
            slot_nxt = slot_inc;
            if (slot_inc >= dsr_pkg::SLOT_W'(CHANNELS)) phase_nxt = dsr_pkg::PH_IDLE;
          end
          default: begin
            // idle: drop the byte
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= dsr_pkg::PH_IDLE;
      slot_r   <= '0;
      levels_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      slot_r   <= slot_nxt;
      levels_r <= levels_nxt;
    end
  end

  assign phase_code_nxt = dsr_pkg::phase_code(phase_nxt);
  assign levels         = levels_r;

  // Capture never runs past the channel window
  a_capture_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == dsr_pkg::PH_CAPTURE |-> slot_r < dsr_pkg::SLOT_W'(CHANNELS))
    else $error("slot counter outside channel window during capture");

  // A break always lands in the after-break phase with the start address
  a_break_loads: assert property (@(posedge clk) disable iff (!rst_n)
    step_i.byte_en && step_i.brk |=>
      phase_r == dsr_pkg::PH_BREAK && slot_r == $past(start_address))
    else $error("break did not reload the slot counter");

endmodule

FILE: rtl/dsr_pwm.sv
// ----------------------------------------------------------------------------
// dsr_pwm
// PWM generator: 8-bit tick counter, level latch on wrap and per-channel
// compare that clears each output bit.
// ----------------------------------------------------------------------------
module dsr_pwm #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  dsr_pkg::step_t                           step_i,
  input  logic [CHANNELS-1:0][dsr_pkg::BYTE_W-1:0] levels,
  input  logic [dsr_pkg::BYTE_W-1:0]               invert_mask,
  output logic [dsr_pkg::PINS_W-1:0]               shown
);

  localparam int unsigned PAD_W = (CHANNELS > dsr_pkg::PINS_W) ? CHANNELS : dsr_pkg::PINS_W;

  logic [dsr_pkg::BYTE_W-1:0]               cnt_r, cnt_nxt;
  logic [dsr_pkg::BYTE_W-1:0]               cnt_inc;
  logic [CHANNELS-1:0][dsr_pkg::BYTE_W-1:0] latched_r, latched_nxt;
  logic [CHANNELS-1:0]                      bits_r, bits_nxt;
  logic [PAD_W-1:0]                         bits_pad;

  assign cnt_inc = cnt_r + 8'd1;

  // Advance the counter on each tick transfer; latch and set on wrap
  always_comb begin
    cnt_nxt     = cnt_r;
    latched_nxt = latched_r;
    bits_nxt    = bits_r;
    if (step_i.tick_en) begin
      cnt_nxt = cnt_inc;
      if (cnt_inc == '0) begin
        latched_nxt = levels;
        bits_nxt    = '1;
      end
      for (int unsigned i = 0; i < CHANNELS; i++) begin
        if (cnt_inc == latched_nxt[i]) bits_nxt[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= dsr_pkg::TICK_COUNT_RST;
      latched_r <= '0;
      bits_r    <= '0;
    end else begin
      cnt_r     <= cnt_nxt;
      latched_r <= latched_nxt;
      bits_r    <= bits_nxt;
    end
  end

  // Show the low eight channels before this item's update
  assign bits_pad = PAD_W'(bits_r);
  assign shown    = bits_pad[dsr_pkg::PINS_W-1:0] ^ invert_mask;

  // A wrapping tick takes a fresh copy of the received levels
  a_wrap_latch: assert property (@(posedge clk) disable iff (!rst_n)
    step_i.tick_en && cnt_r == 8'hff |=> cnt_r == '0 && latched_r == $past(levels))
    else $error("counter wrap did not latch received levels");

  // Only ticks move the counter
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step_i.tick_en |=> $stable(cnt_r))
    else $error("tick counter moved without a tick");

endmodule
